/* rtl/utgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utgr_pkg
// Shared constants, operation codes and sequencer types for the glyph renderer.
// ----------------------------------------------------------------------------
package utgr_pkg;
    localparam int FONT_BYTES_DEF      = 4096;
    localparam int MAX_GLYPH_WIDTH_DEF = 64;
    localparam int MAX_GLYPH_ROWS_DEF  = 64;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PEN   = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] MASK_TWO   = 8'h1F;
    localparam logic [7:0] MASK_CONT  = 8'h3F;
    localparam logic [7:0] MASK_THREE = 8'h0F;

    // Request from the decoder to the glyph sequencer.
    typedef struct packed {
        logic        start;
        logic [15:0] code;
    } utgr_req_t;
endpackage

/* rtl/utgr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utgr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module utgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/utgr_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utgr_decode
// UTF-8 byte decoder: collects lead and continuation bytes into code points.
// ----------------------------------------------------------------------------
module utgr_decode
    import utgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       byte_valid,
    input  logic [7:0] byte_in,
    output utgr_req_t  req
);
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  pending_reg, pending_next;
    utgr_req_t   req_c;

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        req_c        = '0;
        if (clear)
        begin
            partial_next = '0;
            pending_next = '0;
        end
        else if (byte_valid)
        begin
            if (pending_reg == 2'd0)
            begin
                if (byte_in < LEAD_TWO)
                begin
                    req_c.start = (byte_in != 8'd0);
                    req_c.code  = {8'd0, byte_in};
                end
                else if (byte_in < LEAD_THREE)
                begin
                    partial_next = {5'd0, byte_in[4:0] & MASK_TWO[4:0], 6'd0};
                    pending_next = 2'd1;
                end
                else
                begin
                    partial_next = {byte_in[3:0] & MASK_THREE[3:0], 12'd0};
                    pending_next = 2'd2;
                end
            end
            else if (pending_reg == 2'd2)
            begin
                partial_next = partial_reg | {4'd0, byte_in[5:0] & MASK_CONT[5:0], 6'd0};
                pending_next = 2'd1;
            end
            else
            begin
                req_c.code   = partial_reg | {10'd0, byte_in[5:0] & MASK_CONT[5:0]};
                req_c.start  = (req_c.code != 16'd0);
                partial_next = '0;
                pending_next = '0;
            end
        end
    end

    assign req = req_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
        end
        else
        begin
            a_pend_range: assert (pending_reg != 2'd3)
                else $error("decoder pending count out of range");
        end
    end
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> pending_reg == 2'd0)
        else $error("decoder not cleared");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> byte_valid && !clear)
        else $error("code point without a byte");
endmodule

/* rtl/utgr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utgr_seq
// Glyph sequencer: walks the font table, reads the header, emits bitmap rows.
// ----------------------------------------------------------------------------
module utgr_seq
    import utgr_pkg::*;
#(
    parameter int FONT_BYTES      = FONT_BYTES_DEF,
    parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF,
    parameter int MAX_GLYPH_ROWS  = MAX_GLYPH_ROWS_DEF,
    localparam int AW = $clog2(FONT_BYTES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  utgr_req_t          req,
    input  logic [11:0]        font_base,
    input  logic               pen_load,
    input  logic [9:0]         pen_x_in,
    input  logic [8:0]         pen_y_in,
    input  logic [23:0]        ink_in,
    output logic               busy,
    output logic [AW-1:0]      rd_addr,
    input  logic [7:0]         rd_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] row_x,
    output logic signed [10:0] row_y,
    output logic [63:0]        row_bits,
    output logic [6:0]         row_width,
    output logic [23:0]        ink,
    output logic               glyph_missing,
    output logic               last
);
    localparam logic [3:0] S_IDLE = 4'd0, S_CNT0 = 4'd1, S_CNT1 = 4'd2, S_ENT = 4'd3,
        S_HDR = 4'd4, S_ROW = 4'd5, S_EMIT = 4'd6, S_WAIT = 4'd7;

    logic [3:0]  state_reg;
    logic        rv_reg;                  // a read was issued last cycle
    logic [2:0]  rsub_reg;                // byte index within entry or header
    logic [15:0] code_reg;
    logic [15:0] count_reg, idx_reg;
    logic [AW-1:0] ptr_reg;               // next byte address to read
    logic [7:0]  b0_reg, b1_reg, b2_reg;
    logic [7:0]  adv_reg, bw_reg, bh_reg, bx_reg, by_reg;
    logic [6:0]  h_reg, r_reg;
    logic [AW-1:0] rowaddr_reg;
    logic [3:0]  col_reg;                 // byte within row
    logic [63:0] bits_reg;
    logic [11:0] pen_x_reg;
    logic [8:0]  pen_y_reg;
    logic [23:0] ink_reg;
    logic        ov_reg;

    logic [6:0] w_sat, h_sat;
    logic [5:0] stride;
    assign w_sat  = (bw_reg > 8'(MAX_GLYPH_WIDTH)) ? 7'(MAX_GLYPH_WIDTH) : bw_reg[6:0];
    assign h_sat  = (bh_reg > 8'(MAX_GLYPH_ROWS)) ? 7'(MAX_GLYPH_ROWS) : bh_reg[6:0];
    assign stride = 6'(({1'b0, bw_reg} + 9'd7) >> 3);

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = ptr_reg;

    logic [63:0] width_mask;
    assign width_mask = (w_sat >= 7'd64) ? '1 : ((64'd1 << w_sat) - 64'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            ink_reg   <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (pen_load)
            begin
                pen_x_reg <= {2'd0, pen_x_in};
                pen_y_reg <= pen_y_in;
                ink_reg   <= ink_in;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        code_reg  <= req.code;
                        ptr_reg   <= AW'(font_base);
                        rv_reg    <= 1'b1;
                        rsub_reg  <= 3'd0;
                        state_reg <= S_CNT0;
                    end
                end
                S_CNT0:
                begin
                    ptr_reg   <= AW'(font_base) + AW'(1);
                    rv_reg    <= 1'b1;
                    state_reg <= S_CNT1;
                end
                S_CNT1:
                begin
                    // rd_data holds count low byte now
                    b0_reg    <= rd_data;
                    state_reg <= S_ENT;
                    idx_reg   <= '0;
                    ptr_reg   <= AW'(font_base) + AW'(2);
                    rsub_reg  <= 3'd7;
                end
                S_ENT:
                begin
                    if (rsub_reg == 3'd7)
                    begin
                        count_reg <= {rd_data, b0_reg};
                        rsub_reg  <= 3'd0;
                        if ({rd_data, b0_reg} == 16'd0)
                        begin
                            state_reg <= S_WAIT;
                        end
                        else
                        begin
                            rv_reg  <= 1'b1;
                            ptr_reg <= ptr_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        // one byte read per cycle; data for byte rsub arrives
                        case (rsub_reg)
                            3'd0: b0_reg <= rd_data;
                            3'd1: b1_reg <= rd_data;
                            3'd2: b2_reg <= rd_data;
                            default: ;
                        endcase
                        if (rsub_reg == 3'd3)
                        begin
                            if ({b1_reg, b0_reg} == code_reg)
                            begin
                                ptr_reg   <= AW'(font_base) + AW'({rd_data, b2_reg});
                                rv_reg    <= 1'b1;
                                rsub_reg  <= 3'd0;
                                state_reg <= S_HDR;
                            end
                            else if (idx_reg + 16'd1 == count_reg)
                            begin
                                state_reg <= S_WAIT;
                            end
                            else
                            begin
                                idx_reg  <= idx_reg + 16'd1;
                                rsub_reg <= 3'd0;
                                rv_reg   <= 1'b1;
                                ptr_reg  <= ptr_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            rsub_reg <= rsub_reg + 3'd1;
                            rv_reg   <= 1'b1;
                            ptr_reg  <= ptr_reg + AW'(1);
                        end
                    end
                end
                S_HDR:
                begin
                    // The first cycle presents the header address; its bytes
                    // arrive in the cycle after their addresses.
                    case (rsub_reg)
                        3'd1: adv_reg <= rd_data;
                        3'd2: bw_reg  <= rd_data;
                        3'd3: bh_reg  <= rd_data;
                        3'd4: bx_reg  <= rd_data;
                        3'd5: by_reg  <= rd_data;
                        default: ;
                    endcase
                    ptr_reg <= ptr_reg + AW'(1);
                    if (rsub_reg == 3'd5)
                    begin
                        rowaddr_reg <= ptr_reg;
                        r_reg       <= '0;
                        state_reg   <= S_ROW;
                        col_reg     <= '0;
                        bits_reg    <= '0;
                        h_reg       <= 7'd0;
                    end
                    else
                    begin
                        rsub_reg <= rsub_reg + 3'd1;
                        rv_reg   <= 1'b1;
                    end
                end
                S_ROW:
                begin
                    // Fetch the needed bytes of one row, then emit it. A byte is
                    // captured once its address has passed ptr_reg and the RAM read register.
                    h_reg <= h_sat;
                    if (h_sat == 7'd0 || w_sat == 7'd0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (col_reg == 4'd0 && !rv_reg)
                    begin
                        ptr_reg <= rowaddr_reg;
                        rv_reg  <= 1'b1;
                        col_reg <= 4'd1;
                    end
                    else if (!rv_reg)
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            bits_reg[{col_reg[2:0] - 3'd1, 3'(k)}] <= rd_data[7 - k];
                        end
                        if (col_reg == 4'((w_sat + 7'd7) >> 3))
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + AW'(1);
                            rv_reg  <= 1'b1;
                            col_reg <= col_reg + 4'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg        <= 1'b1;
                        glyph_missing <= 1'b0;
                        row_x         <= 14'(signed'({2'd0, pen_x_reg})
                                         + 14'(signed'(bx_reg)));
                        row_y         <= 11'(signed'({2'd0, pen_y_reg})
                                         + 11'(signed'(by_reg)) + 11'(r_reg));
                        row_bits      <= (h_reg == 7'd0) ? '0 : (bits_reg & width_mask);
                        row_width     <= (h_reg == 7'd0) ? 7'd0 : w_sat;
                        ink           <= ink_reg;
                        if (h_reg == 7'd0 || r_reg + 7'd1 == h_reg)
                        begin
                            last      <= 1'b1;
                            pen_x_reg <= pen_x_reg + {4'd0, adv_reg};
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            last        <= 1'b0;
                            r_reg       <= r_reg + 7'd1;
                            rowaddr_reg <= rowaddr_reg + AW'(stride);
                            col_reg     <= '0;
                            bits_reg    <= '0;
                            state_reg   <= S_ROW;
                        end
                    end
                end
                S_WAIT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg        <= 1'b1;
                        glyph_missing <= 1'b1;
                        last          <= 1'b1;
                        row_x         <= '0;
                        row_y         <= '0;
                        row_bits      <= '0;
                        row_width     <= '0;
                        ink           <= ink_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg)
        else $error("result dropped under stall");
    a_idle_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE)
        else $error("code point arrived while busy");
    a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && glyph_missing |-> last)
        else $error("missing glyph result not final");
endmodule

/* rtl/utf8_text_glyph_renderer_top.sv */
`timescale 1ns / 1ps
// A code point reads the entry count, searches the table entries in order and reads the
// glyph header; each row then fetches its bitmap bytes and is emitted. A missing glyph
// result is registered once the search ends. One item is taken at a time: in_stall is
// high while the sequencer is busy; op 0, op 1 and bytes that finish no code point
// leave it idle. Output stalls keep it busy; one font port serves writes and reads.
// Reset clears the decoder, pen, ink and font_base; the font memory is not cleared.
// ----------------------------------------------------------------------------
// utf8_text_glyph_renderer_top
// Bitmap font character generator with UTF-8 input and one font memory.
// ----------------------------------------------------------------------------
module utf8_text_glyph_renderer_top
    import utgr_pkg::*;
#(
    parameter int FONT_BYTES      = FONT_BYTES_DEF,
    parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF,
    parameter int MAX_GLYPH_ROWS  = MAX_GLYPH_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [11:0]        font_addr,
    input  logic [7:0]         data_byte,
    input  logic [9:0]         start_x,
    input  logic [8:0]         start_y,
    input  logic [23:0]        color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] row_x,
    output logic signed [10:0] row_y,
    output logic [63:0]        row_bits,
    output logic [6:0]         row_width,
    output logic [23:0]        ink,
    output logic               glyph_missing,
    output logic               last
);
    localparam int AW = $clog2(FONT_BYTES);

    logic [11:0]   font_base_reg;
    logic          busy, accept, mem_we;
    logic [AW-1:0] seq_addr, mem_addr;
    logic [7:0]    mem_rdata;
    utgr_req_t     req;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;
    assign mem_we   = accept && (op == OP_WRITE);
    assign mem_addr = mem_we ? AW'(font_addr) : seq_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            font_base_reg <= cfg_wdata;
        end
    end

    utgr_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept && op == OP_PEN),
        .byte_valid (accept && op == OP_TEXT),
        .byte_in    (data_byte),
        .req        (req)
    );

    utgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (data_byte),
        .rdata (mem_rdata)
    );

    utgr_seq #(
        .FONT_BYTES      (FONT_BYTES),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .font_base     (font_base_reg),
        .pen_load      (accept && op == OP_PEN),
        .pen_x_in      (start_x),
        .pen_y_in      (start_y),
        .ink_in        (color),
        .busy          (busy),
        .rd_addr       (seq_addr),
        .rd_data       (mem_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_x         (row_x),
        .row_y         (row_y),
        .row_bits      (row_bits),
        .row_width     (row_width),
        .ink           (ink),
        .glyph_missing (glyph_missing),
        .last          (last)
    );

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !busy)
        else $error("font write while sequencer busy");
endmodule

/* tb/utf8_text_glyph_renderer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_glyph_renderer_top_tb
// Only font bytes that get read are written: a small font at the bottom, a
// one-entry font near the top whose glyph offset wraps, and an empty font.
// Directed UTF-8 text runs under the first two bases, short random streams
// under each. Each row transfer is checked against a local renderer model.
// ----------------------------------------------------------------------------
module utf8_text_glyph_renderer_top_tb;
    import utgr_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int MEM_SIZE = 4096;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [9:0]  sx;
        logic [8:0]  sy;
        logic [23:0] col;
    } text_cmd_t;

    typedef struct packed {
        logic [13:0] x;
        logic [10:0] y;
        logic [63:0] bits;
        logic [6:0]  w;
        logic [23:0] ink;
        logic        miss;
        logic        last;
    } glyph_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [11:0] font_addr;
    logic [7:0]  data_byte;
    logic [9:0]  start_x;
    logic [8:0]  start_y;
    logic [23:0] color;
    logic        out_valid;
    logic        out_stall;
    logic signed [13:0] row_x;
    logic signed [10:0] row_y;
    logic [63:0] row_bits;
    logic [6:0]  row_width;
    logic [23:0] ink;
    logic        glyph_missing;
    logic        last;

    utf8_text_glyph_renderer_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .font_addr(font_addr),
        .data_byte(data_byte), .start_x(start_x), .start_y(start_y), .color(color),
        .out_valid(out_valid), .out_stall(out_stall), .row_x(row_x), .row_y(row_y),
        .row_bits(row_bits), .row_width(row_width), .ink(ink),
        .glyph_missing(glyph_missing), .last(last)
    );

    text_cmd_t  pending_cmds[$];
    glyph_row_t expected_rows[$];
    int         errors;
    bit         quiet;
    bit         took;
    int         in_gap;
    int         out_gap;

    // Local copy of the renderer state.
    logic [7:0]  fmem[MEM_SIZE];
    logic [11:0] m_base;
    logic [15:0] m_partial;
    logic [1:0]  m_pending;
    logic [11:0] m_pen_x;
    logic [8:0]  m_pen_y;
    logic [23:0] m_ink;

    // Codes present in the font at base 0.
    int font_codes[5] = '{'h41, 'h7F, 'h3A9, 'h20AC, 'h123};

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int rd(int a);
        return fmem[a % MEM_SIZE];
    endfunction

    function automatic int sx8(int v);
        return (v & 'h80) ? v - 256 : v;
    endfunction

    function automatic void render_code(int code);
        int count, i, e, glyph, adv, bw, bh, bx, by, stride, w, h, x0, y0, rowaddr;
        int r, c;
        bit found;
        glyph_row_t row;
        count = rd(m_base) | (rd(m_base + 1) << 8);
        found = 0;
        glyph = 0;
        for (i = 0; i < count && !found; i++) begin
            e = m_base + 2 + i * 4;
            if ((rd(e) | (rd(e + 1) << 8)) == code) begin
                glyph = m_base + (rd(e + 2) | (rd(e + 3) << 8));
                found = 1;
            end
        end
        row = '0;
        row.ink = m_ink;
        if (!found) begin
            row.miss = 1'b1;
            row.last = 1'b1;
            expected_rows.push_back(row);
            return;
        end
        adv = rd(glyph);
        bw = rd(glyph + 1);
        bh = rd(glyph + 2);
        bx = sx8(rd(glyph + 3));
        by = sx8(rd(glyph + 4));
        stride = (bw + 7) / 8;
        w = bw > 64 ? 64 : bw;
        h = bh > 64 ? 64 : bh;
        x0 = int'(m_pen_x) + bx;
        y0 = int'(m_pen_y) + by;
        rowaddr = glyph + 5;
        row.x = x0[13:0];
        if (h == 0) begin
            row.y = y0[10:0];
            row.last = 1'b1;
            expected_rows.push_back(row);
        end else begin
            for (r = 0; r < h; r++) begin
                row.bits = '0;
                for (c = 0; c < w; c++)
                    if (rd(rowaddr + (c >> 3)) & ('h80 >> (c & 7)))
                        row.bits[c] = 1'b1;
                row.y = 11'(y0 + r);
                row.w = w[6:0];
                row.last = (r + 1 == h);
                expected_rows.push_back(row);
                rowaddr += stride;
            end
        end
        m_pen_x = 12'(int'(m_pen_x) + adv);
    endfunction

    function automatic void apply_cmd(text_cmd_t t);
        int code;
        code = -1;
        case (t.op)
            OP_WRITE: fmem[t.addr] = t.data;
            OP_PEN: begin
                m_pen_x = {2'b0, t.sx};
                m_pen_y = t.sy;
                m_ink = t.col;
                m_partial = '0;
                m_pending = '0;
            end
            OP_TEXT: begin
                if (m_pending == 0) begin
                    if (t.data == 0) code = -1;
                    else if (t.data < LEAD_TWO) code = t.data;
                    else if (t.data < LEAD_THREE) begin
                        m_partial = 16'(t.data & MASK_TWO) << 6;
                        m_pending = 2'd1;
                    end else begin
                        m_partial = 16'(t.data & MASK_THREE) << 12;
                        m_pending = 2'd2;
                    end
                end else if (m_pending == 2) begin
                    m_partial = m_partial | (16'(t.data & MASK_CONT) << 6);
                    m_pending = 2'd1;
                end else begin
                    code = m_partial | 16'(t.data & MASK_CONT);
                    m_partial = '0;
                    m_pending = '0;
                end
                if (code > 0) render_code(code);
            end
            default: ;
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] o, logic [11:0] a, logic [7:0] d);
        text_cmd_t t;
        t.op = o;
        t.addr = a;
        t.data = d;
        t.sx = 10'($urandom);
        t.sy = 9'($urandom);
        t.col = 24'($urandom);
        pending_cmds.push_back(t);
    endtask

    task automatic push_pen(logic [9:0] x, logic [8:0] y, logic [23:0] c);
        text_cmd_t t;
        t.op = OP_PEN;
        t.addr = 12'($urandom);
        t.data = 8'($urandom);
        t.sx = x;
        t.sy = y;
        t.col = c;
        pending_cmds.push_back(t);
    endtask

    task automatic push_char(int code);
        if (code < 'h80) push_cmd(OP_TEXT, 0, 8'(code));
        else if (code < 'h800) begin
            push_cmd(OP_TEXT, 0, 8'('hC0 | (code >> 6)));
            push_cmd(OP_TEXT, 0, 8'('h80 | (code & 'h3F)));
        end else begin
            push_cmd(OP_TEXT, 0, 8'('hE0 | (code >> 12)));
            push_cmd(OP_TEXT, 0, 8'('h80 | ((code >> 6) & 'h3F)));
            push_cmd(OP_TEXT, 0, 8'('h80 | (code & 'h3F)));
        end
    endtask

    task automatic put_glyph(int a, int adv, int w, int h, int bx, int by);
        push_cmd(OP_WRITE, 12'(a), 8'(adv));
        push_cmd(OP_WRITE, 12'(a + 1), 8'(w));
        push_cmd(OP_WRITE, 12'(a + 2), 8'(h));
        push_cmd(OP_WRITE, 12'(a + 3), 8'(bx));
        push_cmd(OP_WRITE, 12'(a + 4), 8'(by));
    endtask

    task automatic put_bits(int a, int n);
        int k;
        for (k = 0; k < n; k++) push_cmd(OP_WRITE, 12'(a + k), 8'($urandom));
    endtask

    task automatic put_entry(int base, int idx, int code, int off);
        int e;
        e = base + 2 + idx * 4;
        push_cmd(OP_WRITE, 12'(e), 8'(code));
        push_cmd(OP_WRITE, 12'(e + 1), 8'(code >> 8));
        push_cmd(OP_WRITE, 12'(e + 2), 8'(off));
        push_cmd(OP_WRITE, 12'(e + 3), 8'(off >> 8));
    endtask

    // Mostly well-formed characters, with stray bytes, pen moves, bitmap
    // rewrites and ignored commands mixed in.
    task automatic random_text(int n);
        int k, sel;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                if ($urandom_range(0, 3) == 0) push_char($urandom_range(1, 'hFFFF));
                else push_char(font_codes[$urandom_range(0, 4)]);
            end else if (sel < 75) push_cmd(OP_TEXT, 0, 8'($urandom));
            else if (sel < 85) push_pen(10'($urandom), 9'($urandom), 24'($urandom));
            else if (sel < 95) push_cmd(OP_WRITE, 12'($urandom_range('h105, 'h107)),
                                        8'($urandom));
            else push_cmd(OP_NONE, 12'($urandom), 8'($urandom));
        end
    endtask

    task automatic settle();
        do @(posedge clk);
        while (!(pending_cmds.size() == 0 && !in_valid && expected_rows.size() == 0));
        repeat (60) @(posedge clk);
    endtask

    task automatic set_base(logic [11:0] b);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= b;
        m_base = b;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // Driver: the payload holds until the transfer completes.
    always @(posedge clk)
        if (rst_n && in_valid && !in_stall) begin
            took = 1'b1;
            apply_cmd(pending_cmds.pop_front());
        end

    always @(negedge clk)
        if (rst_n && (!in_valid || took)) begin
            took = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(1, 10) - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                in_valid <= 1'b1;
                op <= pending_cmds[0].op;
                font_addr <= pending_cmds[0].addr;
                data_byte <= pending_cmds[0].data;
                start_x <= pending_cmds[0].sx;
                start_y <= pending_cmds[0].sy;
                color <= pending_cmds[0].col;
            end else
                in_valid <= 1'b0;
        end

    always @(negedge clk)
        if (rst_n) begin
            if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end else
                out_stall <= 1'b0;
        end

    // Monitor.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) begin
            glyph_row_t want;
            if (expected_rows.size() == 0) begin
                $display("row transfer with no row expected");
                errors++;
            end else begin
                want = expected_rows.pop_front();
                if (row_x !== want.x) report("row_x", row_x, want.x);
                if (row_y !== want.y) report("row_y", row_y, want.y);
                if (row_bits !== want.bits) report("row_bits", row_bits, want.bits);
                if (row_width !== want.w) report("row_width", row_width, want.w);
                if (ink !== want.ink) report("ink", ink, want.ink);
                if (glyph_missing !== want.miss)
                    report("glyph_missing", glyph_missing, want.miss);
                if (last !== want.last) report("last", last, want.last);
            end
        end

    initial begin
        #20_000_000;
        $display("** utf8_text_glyph_renderer_top: FAILED **");
        $finish;
    end

    initial begin
        errors = 0;
        quiet = 0;
        took = 0;
        in_gap = 0;
        out_gap = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_WRITE;
        font_addr = '0;
        data_byte = '0;
        start_x = '0;
        start_y = '0;
        color = '0;
        out_stall = 1'b0;
        m_base = '0;
        m_partial = '0;
        m_pending = '0;
        m_pen_x = '0;
        m_pen_y = '0;
        m_ink = '0;
        foreach (fmem[k]) fmem[k] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_base(12'd0);

        // Font at base 0. Only the bytes that a lookup or a row fetch reads
        // are written.
        push_cmd(OP_WRITE, 12'd0, 8'd5);
        push_cmd(OP_WRITE, 12'd1, 8'd0);
        put_entry(0, 0, 'h41, 'h100);
        put_entry(0, 1, 'h7F, 'h160);
        put_entry(0, 2, 'h3A9, 'h120);
        put_entry(0, 3, 'h20AC, 'h140);
        put_entry(0, 4, 'h123, 'h170);
        put_glyph('h100, 8, 8, 3, 0, 'hF8);
        put_bits('h105, 3);
        // Tall glyph with no columns: height saturates, no bitmap is fetched.
        put_glyph('h160, 255, 0, 70, 'h80, 'h7F);
        put_glyph('h120, 12, 12, 2, 2, 0);
        put_bits('h125, 4);
        // Wide glyph: width saturates to 64 columns, stride stays 9 bytes.
        put_glyph('h140, 20, 70, 1, 'hFD, 5);
        put_bits('h145, 8);
        put_glyph('h170, 5, 9, 0, 1, 1);
        // Font near the top of memory; its glyph offset wraps to the bottom.
        push_cmd(OP_WRITE, 12'hFF0, 8'd1);
        push_cmd(OP_WRITE, 12'hFF1, 8'd0);
        put_entry('hFF0, 0, 'h41, 'h110);
        // Empty font.
        push_cmd(OP_WRITE, 12'hC00, 8'd0);
        push_cmd(OP_WRITE, 12'hC01, 8'd0);

        // Directed text.
        push_pen(10'd0, 9'd0, 24'h000000);
        push_char('h41);
        push_cmd(OP_TEXT, 0, 8'h00);
        push_char('h3A9);
        push_char('h20AC);
        push_char('h7A);
        push_char('h123);
        push_char('hFFFF);
        push_cmd(OP_TEXT, 0, 8'h80);
        push_cmd(OP_TEXT, 0, 8'h41);
        push_cmd(OP_TEXT, 0, 8'hC0);
        push_cmd(OP_TEXT, 0, 8'h00);
        push_cmd(OP_NONE, 12'hFFF, 8'hFF);
        push_cmd(OP_TEXT, 0, 8'hE2);
        push_pen(10'd1023, 9'd511, 24'hFFFFFF);
        push_char('h7F);
        push_char('h7F);
        random_text(6);
        settle();

        set_base(12'hFF0);
        push_char('h41);
        random_text(4);
        settle();

        set_base(12'hC00);
        random_text(2);
        settle();

        set_base(12'd0);
        random_text(4);
        quiet = 1;
        random_text(4);
        settle();

        if (errors == 0)
            $display("** utf8_text_glyph_renderer_top: PASSED **");
        else
            $display("** utf8_text_glyph_renderer_top: FAILED **");
        $finish;
    end
endmodule
